// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

    // fixed field widths
    localparam int MODE_W = 2;
    localparam int OUTCOME_W = 3;
    localparam int TOTAL_W = 32;
    localparam int SET_BITS_W = 3;
    localparam int WAYS_CFG_W = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int BLOCK_BITS_MAX = (1 << BLOCK_BITS_W) - 1;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    // access kinds
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_MISS = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_HIT = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_HIT = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_EVICT = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_EVICT_HIT = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_status_t;

endpackage

// ===== rtl/sacl_req_if.sv =====
interface sacl_req_if #(
    parameter int ADDRESS_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic [sacl_pkg::MODE_W-1:0]    mode;
    logic [ADDRESS_WIDTH-1:0]       address;

    modport source (output valid, output mode, output address, input ready);
    modport sink (input valid, input mode, input address, output ready);
endinterface

// ===== rtl/sacl_rsp_if.sv =====
interface sacl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [sacl_pkg::OUTCOME_W-1:0]   outcome;
    logic [sacl_pkg::TOTAL_W-1:0]     hit_total;
    logic [sacl_pkg::TOTAL_W-1:0]     miss_total;
    logic [sacl_pkg::TOTAL_W-1:0]     eviction_total;

    modport source (output valid, output outcome, output hit_total, output miss_total,
                    output eviction_total, input ready);
    modport sink (input valid, input outcome, input hit_total, input miss_total,
                  input eviction_total, output ready);
endinterface

// ===== rtl/sacl_ctrl.sv =====
module sacl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sacl_pkg::ctrl_status_t status,
    output sacl_pkg::ctrl_cmd_t   cmd
);

    sacl_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // state and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            sacl_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = sacl_pkg::ST_IDLE;
            end
            sacl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP:
            begin
                // finish only once the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacl_pkg::ST_CLEAR;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/sacl_dpath.sv =====
module sacl_dpath #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS = 8,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sacl_pkg::ctrl_cmd_t                 cmd,
    output sacl_pkg::ctrl_status_t              status,
    input  logic                                cfg_we,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sacl_pkg::MODE_W-1:0]         req_mode,
    input  logic [ADDRESS_WIDTH-1:0]            req_address,
    output logic [sacl_pkg::OUTCOME_W-1:0]      outcome,
    output logic [sacl_pkg::TOTAL_W-1:0]        hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]        miss_total,
    output logic [sacl_pkg::TOTAL_W-1:0]        eviction_total
);

    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int SHIFT_W = $clog2(sacl_pkg::BLOCK_BITS_MAX + MAX_SET_BITS + 1);
    localparam int TW = sacl_pkg::TOTAL_W;

    // configuration registers
    logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_reg;
    logic [sacl_pkg::WAYS_CFG_W-1:0]   ways_reg;
    logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_reg;

    // set memories: valid bits, tags and recency ranks, one row per set
    logic [MAX_WAYS-1:0]                    valid_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tag_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][WAY_W-1:0]         rank_mem [NUM_SETS];

    logic [MAX_WAYS-1:0]                    valid_rd_reg;
    logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tag_rd_reg;
    logic [MAX_WAYS-1:0][WAY_W-1:0]         rank_rd_reg;

    logic [SET_AW-1:0]        set_reg;
    logic [ADDRESS_WIDTH-1:0] tag_reg;
    logic                     modify_reg;
    logic [SET_AW-1:0]        clr_addr_reg;

    logic [TW-1:0] hit_reg, hit_next;
    logic [TW-1:0] miss_reg, miss_next;
    logic [TW-1:0] evict_reg, evict_next;
    logic [sacl_pkg::OUTCOME_W-1:0] outcome_reg, outcome_next;

    logic [SHIFT_W-1:0]       sbits_eff;
    logic [WCNT_W-1:0]        ways_eff;
    logic [ADDRESS_WIDTH-1:0] addr_shifted;
    logic [SET_AW-1:0]        set_mask;
    logic [SET_AW-1:0]        set_in;
    logic [ADDRESS_WIDTH-1:0] tag_in;

    logic [MAX_WAYS-1:0] way_used;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] empty_vec;
    logic                hit;
    logic                has_empty;
    logic                was_valid;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    empty_way;
    logic [WAY_W-1:0]    victim_way;
    logic [WAY_W-1:0]    best_rank;
    logic [WAY_W-1:0]    way_sel;
    logic [WAY_W-1:0]    old_rank;

    logic [MAX_WAYS-1:0]                    valid_wr;
    logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tag_wr;
    logic [MAX_WAYS-1:0][WAY_W-1:0]         rank_wr;

    logic [1:0]    hit_inc;
    logic [TW:0]   hit_sum;
    logic [TW:0]   miss_sum;
    logic [TW:0]   evict_sum;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= '0;
            ways_reg <= sacl_pkg::WAYS_CFG_W'(1);
            block_bits_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sacl_pkg::CFG_SET_INDEX_BITS:
                    set_bits_reg <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
                sacl_pkg::CFG_WAYS_IN_USE:
                    ways_reg <= cfg_data[sacl_pkg::WAYS_CFG_W-1:0];
                sacl_pkg::CFG_BLOCK_OFFSET_BITS:
                    block_bits_reg <= cfg_data[sacl_pkg::BLOCK_BITS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective geometry
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
            sbits_eff = SHIFT_W'(MAX_SET_BITS);
        else
            sbits_eff = SHIFT_W'(set_bits_reg);

        if (ways_reg == '0)
            ways_eff = WCNT_W'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = WCNT_W'(ways_reg);
    end

    // address split into set index and tag
    always_comb
    begin
        addr_shifted = req_address >> block_bits_reg;
        set_mask = ~({SET_AW{1'b1}} << sbits_eff);
        set_in = addr_shifted[SET_AW-1:0] & set_mask;
        tag_in = req_address >> (SHIFT_W'(block_bits_reg) + sbits_eff);
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + SET_AW'(1);
    end

    assign status.clear_last = (clr_addr_reg == SET_AW'(NUM_SETS - 1));

    // valid memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            valid_mem[clr_addr_reg] <= '0;
        else if (cmd.commit)
            valid_mem[set_reg] <= valid_wr;
        if (cmd.load)
            valid_rd_reg <= valid_mem[set_in];
    end

    // tag memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            tag_mem[set_reg] <= tag_wr;
        if (cmd.load)
            tag_rd_reg <= tag_mem[set_in];
    end

    // rank memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rank_mem[set_reg] <= rank_wr;
        if (cmd.load)
            rank_rd_reg <= rank_mem[set_in];
    end

    // access word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
            modify_reg <= (req_mode == sacl_pkg::MODE_MODIFY);
        end
    end

    // tag compare, empty way and victim search
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            way_used[i] = (i < int'(ways_eff));
            hit_vec[i] = way_used[i] && valid_rd_reg[i] && (tag_rd_reg[i] == tag_reg);
            empty_vec[i] = way_used[i] && !valid_rd_reg[i];
        end
        hit = |hit_vec;
        has_empty = |empty_vec;

        hit_way = '0;
        empty_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_way = WAY_W'(i);
            if (empty_vec[i])
                empty_way = WAY_W'(i);
        end

        victim_way = '0;
        best_rank = rank_rd_reg[0];
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (way_used[i] && (rank_rd_reg[i] > best_rank))
            begin
                best_rank = rank_rd_reg[i];
                victim_way = WAY_W'(i);
            end
        end

        if (hit)
            way_sel = hit_way;
        else if (has_empty)
            way_sel = empty_way;
        else
            way_sel = victim_way;
        was_valid = hit || !has_empty;
        old_rank = rank_rd_reg[way_sel];
    end

    // row write-back with rank update
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            valid_wr[i] = valid_rd_reg[i];
            tag_wr[i] = tag_rd_reg[i];
            rank_wr[i] = rank_rd_reg[i];
            if (WAY_W'(i) == way_sel)
            begin
                valid_wr[i] = 1'b1;
                tag_wr[i] = tag_reg;
                rank_wr[i] = '0;
            end
            else if (way_used[i] && valid_rd_reg[i])
            begin
                if (was_valid)
                begin
                    if (rank_rd_reg[i] < old_rank)
                        rank_wr[i] = rank_rd_reg[i] + WAY_W'(1);
                end
                else if (rank_rd_reg[i] < WAY_W'(MAX_WAYS - 1))
                begin
                    rank_wr[i] = rank_rd_reg[i] + WAY_W'(1);
                end
            end
        end
    end

    // saturating totals and outcome code
    always_comb
    begin
        if (hit)
            hit_inc = modify_reg ? 2'd2 : 2'd1;
        else
            hit_inc = modify_reg ? 2'd1 : 2'd0;

        hit_sum = {1'b0, hit_reg} + (TW + 1)'(hit_inc);
        miss_sum = {1'b0, miss_reg} + (TW + 1)'(!hit);
        evict_sum = {1'b0, evict_reg} + (TW + 1)'(!hit && !has_empty);
        hit_next = hit_sum[TW] ? '1 : hit_sum[TW-1:0];
        miss_next = miss_sum[TW] ? '1 : miss_sum[TW-1:0];
        evict_next = evict_sum[TW] ? '1 : evict_sum[TW-1:0];

        if (hit)
            outcome_next = sacl_pkg::OUT_HIT;
        else if (has_empty)
            outcome_next = modify_reg ? sacl_pkg::OUT_MISS_HIT : sacl_pkg::OUT_MISS;
        else
            outcome_next = modify_reg ? sacl_pkg::OUT_MISS_EVICT_HIT
                                      : sacl_pkg::OUT_MISS_EVICT;
    end

    // totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
            miss_reg <= '0;
            evict_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hit_reg <= hit_next;
            miss_reg <= miss_next;
            evict_reg <= evict_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            outcome_reg <= outcome_next;
    end

    assign outcome = outcome_reg;
    assign hit_total = hit_reg;
    assign miss_total = miss_reg;
    assign eviction_total = evict_reg;

endmodule

// ===== rtl/set_assoc_cache_lru_tracker.sv =====
// set-associative tag store with lru ranks; one result word per access word
// result word: the set row is read into registers, then compare and write-back fill the
// result register once it is free; a new access word is taken only after write-back
// reset: totals clear, registers go to 0 sets bits, 1 way, 0 offset bits
// after reset a clearing pass empties all 2^MAX_SET_BITS sets (64 by default)
module set_assoc_cache_lru_tracker #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS = 8,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sacl_req_if.sink                          req,
    sacl_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sacl_pkg::ctrl_cmd_t    cmd;
    sacl_pkg::ctrl_status_t status;

    // sequencing
    sacl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // tag store, lru ranks and totals
    sacl_dpath #(
        .MAX_SET_BITS  (MAX_SET_BITS),
        .MAX_WAYS      (MAX_WAYS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_mode       (req.mode),
        .req_address    (req.address),
        .outcome        (rsp.outcome),
        .hit_total      (rsp.hit_total),
        .miss_total     (rsp.miss_total),
        .eviction_total (rsp.eviction_total)
    );

endmodule
